/* rtl/core/dqs_pkg.sv */
// ----------------------------------------------------------------------------
// dqs_pkg
// Shared types, sizes and request/status codes for the deque with search.
// ----------------------------------------------------------------------------
package dqs_pkg;

    localparam int DEPTH    = 16;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int SUM_W    = IDX_W + 1;
    localparam int VAL_W    = 32;
    localparam int REQ_W    = 3;
    localparam int STAT_W   = 2;
    localparam int OUT_DW   = ((CNT_W + 7) / 8) * 8;
    localparam int OUT_UW   = STAT_W + 1;

    typedef logic signed [VAL_W-1:0] value_t;
    typedef logic [IDX_W-1:0]        idx_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic [REQ_W-1:0]        req_t;
    typedef logic [STAT_W-1:0]       stat_t;

    localparam req_t REQ_PUSH_FRONT = 3'd0;
    localparam req_t REQ_PUSH_BACK  = 3'd1;
    localparam req_t REQ_POP_FRONT  = 3'd2;
    localparam req_t REQ_POP_BACK   = 3'd3;
    localparam req_t REQ_SEARCH     = 3'd4;

    localparam stat_t STAT_OK    = 2'd0;
    localparam stat_t STAT_EMPTY = 2'd1;
    localparam stat_t STAT_FULL  = 2'd2;

    localparam idx_t IDX_LAST = IDX_W'(DEPTH - 1);
    localparam cnt_t CNT_FULL = CNT_W'(DEPTH);

    // front + offset, both below DEPTH, folded back into the ring
    function automatic idx_t wrap_add(input idx_t base, input cnt_t offs);
        logic [SUM_W-1:0] sum;
        sum = {1'b0, base} + SUM_W'(offs);
        if (sum >= SUM_W'(DEPTH))
            sum = sum - SUM_W'(DEPTH);
        return sum[IDX_W-1:0];
    endfunction

endpackage

/* rtl/core/deque_with_search_unit.sv */
// ----------------------------------------------------------------------------
// deque_with_search_unit
// Bounded double-ended queue of signed 32-bit values in a circular store,
// with push/pop at both ends and a sequential membership search.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata                 tuser
// s_axis    in   value[31:0]           req_type[2:0]
// m_axis    out  occupancy (zero pad)  status[1:0], found[2]
//
// Push, pop and unused codes finish in the accept cycle; the result is
// registered and shows in the following cycle.
// A search scans the held entries through the single store read port, one
// entry per cycle, and stops early on a hit; on an empty queue it finishes
// without reading the store.
// Reset clears state, front index, count and output valid; the store is not cleared.
// A new request is taken while a result waits only if it drains that cycle.
// ----------------------------------------------------------------------------
module deque_with_search_unit
    import dqs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [VAL_W-1:0]  s_axis_tdata,   // value
    input  logic [REQ_W-1:0]  s_axis_tuser,   // req_type
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_DW-1:0] m_axis_tdata,   // occupancy
    output logic [OUT_UW-1:0] m_axis_tuser    // status, found
);

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_SEARCH = 1'b1;

    value_t mem [DEPTH];
    value_t rd_q_reg;

    logic   state_reg, state_next;
    idx_t   front_reg, front_next;
    cnt_t   count_reg, count_next;
    cnt_t   rd_idx_reg, rd_idx_next;
    logic   rd_pend_reg, rd_pend_next;
    logic   found_reg, found_next;
    value_t srch_val_reg, srch_val_next;

    logic   out_valid_reg, out_valid_next;
    stat_t  out_stat_reg, out_stat_next;
    logic   out_found_reg, out_found_next;
    cnt_t   out_occ_reg, out_occ_next;

    logic   mem_we;
    idx_t   mem_waddr;
    logic   mem_re;
    idx_t   mem_raddr;

    logic   s_fire;
    logic   hit;
    logic   finish;

    assign s_axis_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_axis_tready);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign hit           = rd_pend_reg && (rd_q_reg == srch_val_reg);
    assign finish        = (state_reg == S_SEARCH) && !rd_pend_reg &&
                           (found_reg || (rd_idx_reg >= count_reg));
    assign mem_re        = (state_reg == S_SEARCH) && (rd_idx_reg < count_reg) &&
                           !found_reg && !hit;
    assign mem_raddr     = wrap_add(front_reg, rd_idx_reg);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DW'(out_occ_reg);
    assign m_axis_tuser  = {out_found_reg, out_stat_reg};

    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        rd_pend_next   = mem_re;
        found_next     = found_reg | hit;
        srch_val_next  = srch_val_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_stat_next  = out_stat_reg;
        out_found_next = out_found_reg;
        out_occ_next   = out_occ_reg;
        mem_we         = 1'b0;
        mem_waddr      = front_reg;

        if (mem_re)
            rd_idx_next = rd_idx_reg + 1'b1;

        if (s_fire)
        begin
            out_valid_next = 1'b1;
            out_stat_next  = STAT_OK;
            out_found_next = 1'b0;
            unique case (s_axis_tuser)
                REQ_PUSH_FRONT:
                begin
                    if (count_reg >= CNT_FULL)
                        out_stat_next = STAT_FULL;
                    else
                    begin
                        front_next = (front_reg == '0) ? IDX_LAST : front_reg - 1'b1;
                        mem_we     = 1'b1;
                        mem_waddr  = front_next;
                        count_next = count_reg + 1'b1;
                    end
                end
                REQ_PUSH_BACK:
                begin
                    if (count_reg >= CNT_FULL)
                        out_stat_next = STAT_FULL;
                    else
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = wrap_add(front_reg, count_reg);
                        count_next = count_reg + 1'b1;
                    end
                end
                REQ_POP_FRONT:
                begin
                    if (count_reg == '0)
                        out_stat_next = STAT_EMPTY;
                    else
                    begin
                        front_next = (front_reg == IDX_LAST) ? '0 : front_reg + 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
                REQ_POP_BACK:
                begin
                    if (count_reg == '0)
                        out_stat_next = STAT_EMPTY;
                    else
                        count_next = count_reg - 1'b1;
                end
                REQ_SEARCH:
                begin
                    out_valid_next = 1'b0;
                    state_next     = S_SEARCH;
                    rd_idx_next    = '0;
                    rd_pend_next   = 1'b0;
                    found_next     = 1'b0;
                    srch_val_next  = s_axis_tdata;
                end
                default:
                begin
                end
            endcase
            out_occ_next = count_next;
        end

        if (finish)
        begin
            state_next     = S_IDLE;
            out_valid_next = 1'b1;
            out_stat_next  = STAT_OK;
            out_found_next = found_reg;
            out_occ_next   = count_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= s_axis_tdata;
        if (mem_re)
            rd_q_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            rd_pend_reg   <= rd_pend_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        srch_val_reg  <= srch_val_next;
        out_stat_reg  <= out_stat_next;
        out_found_reg <= out_found_next;
        out_occ_reg   <= out_occ_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("entry count above depth");

    a_no_write_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> !mem_we)
        else $error("store written during search");

    a_found_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[STAT_W]) |-> (m_axis_tuser[STAT_W-1:0] == STAT_OK))
        else $error("found flag with non-ok status");

    a_search_result_slot: assert property (@(posedge clk) disable iff (!rst_n)
        finish |-> (!out_valid_reg))
        else $error("search finished while a result still waits");

endmodule
